// File: rtl/core/object_block_loader_assert.svh
// Assertion macros for the object block loader.
// Depends on clk and rst_n being visible where the macros are used.
`ifndef OBJECT_BLOCK_LOADER_ASSERT_SVH
`define OBJECT_BLOCK_LOADER_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define OBL_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define OBL_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/obl_pkg.sv
// Shared types and constants for the object block loader.
// No dependencies; used by obl_parser, object_block_loader and tb.
package obl_pkg;

  localparam logic [15:0] HDR_CODE  = 16'hCADE;
  localparam logic [15:0] HDR_DATA  = 16'hDADA;
  localparam logic [15:0] HDR_SYM   = 16'hC3B7;
  localparam logic [15:0] HDR_FNAME = 16'hF17E;
  localparam logic [15:0] HDR_LINE  = 16'h715E;
  localparam logic [15:0] LINE_WORDS = 16'd3;

  typedef enum logic [5:0] {
    PH_HEADER = 6'b000001,
    PH_ADDR   = 6'b000010,
    PH_COUNT  = 6'b000100,
    PH_WORDS  = 6'b001000,
    PH_BYTES  = 6'b010000,
    PH_ERROR  = 6'b100000
  } obl_phase_t;

  typedef enum logic [2:0] {
    KIND_NONE  = 3'd0,
    KIND_CODE  = 3'd1,
    KIND_DATA  = 3'd2,
    KIND_SYM   = 3'd3,
    KIND_FNAME = 3'd4,
    KIND_LINE  = 3'd5
  } obl_kind_t;

  typedef enum logic [1:0] {
    ST_WRITE  = 2'd0,
    ST_BADHDR = 2'd1,
    ST_DONE   = 2'd2,
    ST_TRUNC  = 2'd3
  } obl_status_t;

  typedef struct packed {
    logic        valid;
    logic [15:0] addr;
    logic [15:0] data;
    obl_status_t status;
  } obl_result_t;

  typedef struct packed {
    logic at_header;
    logic in_error;
  } obl_pstat_t;

endpackage

// File: rtl/core/object_block_loader.sv
// Channel   | Direction | Handshake          | Payload
// in_       | input     | in_valid/in_stall  | byte_value[7:0], end_of_file
// out_      | output    | out_valid/out_stall| write_address[15:0], write_data[15:0], status
// One byte per cycle while results are not stalled: input register, one parser pass, result register.
// A byte's result is registered after the input register; bytes that make no result leave none.
// Reset is synchronous and active low; it returns the parser to awaiting a header word.
// A stalled result holds in the result register while one more byte may wait in the input register.
// Depends on obl_pkg, obl_parser and object_block_loader_assert.svh.
module object_block_loader import obl_pkg::*; #(
  parameter int ADDR_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte_value,
  input  logic        in_end_of_file,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_write_address,
  output logic [15:0] out_write_data,
  output logic [1:0]  out_status
);

  logic        s1_valid_r;
  logic [7:0]  s1_byte_r;
  logic        s1_eof_r;
  logic        out_valid_r;
  logic [15:0] out_addr_r;
  logic [15:0] out_data_r;
  obl_status_t out_status_r;
  logic        out_free;
  logic        advance;
  obl_result_t res;
  obl_pstat_t  pstat;

  // A byte that makes no result may advance even while the result register is stalled.
  assign out_free = !out_valid_r || !out_stall;
  assign advance  = s1_valid_r && (!res.valid || out_free);
  assign in_stall = s1_valid_r && !advance;

  obl_parser #(
    .ADDR_WIDTH(ADDR_WIDTH)
  ) u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .step_en    (advance),
    .byte_value (s1_byte_r),
    .end_of_file(s1_eof_r),
    .res        (res),
    .pstat      (pstat)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_byte_r <= in_byte_value;
      s1_eof_r  <= in_end_of_file;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && res.valid) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.valid) begin
      out_addr_r   <= res.addr;
      out_data_r   <= res.data;
      out_status_r <= res.status;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_write_address = out_addr_r;
  assign out_write_data    = out_data_r;
  assign out_status        = out_status_r;

`include "object_block_loader_assert.svh"

  `OBL_ASSERT_IMP(a_stall_needs_item, in_stall, s1_valid_r, "input stalled with empty stage")
  `OBL_ASSERT_IMP(a_nonwrite_zero, out_valid_r && (out_status_r != ST_WRITE), (out_addr_r == 16'd0) && (out_data_r == 16'd0), "non-write result carries payload")
  `OBL_ASSERT_NXT(a_eof_restart, advance && s1_eof_r, pstat.at_header, "parser not restarted after end of file")
  `OBL_ASSERT_IMP(a_error_silent, advance && pstat.in_error && !s1_eof_r, !res.valid, "result produced while discarding")

endmodule

// File: rtl/core/obl_parser.sv
// Parser state and per-byte next-state logic of the object block loader.
// Depends on obl_pkg.
module obl_parser import obl_pkg::*; #(
  parameter int ADDR_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step_en,
  input  logic [7:0]  byte_value,
  input  logic        end_of_file,
  output obl_result_t res,
  output obl_pstat_t  pstat
);

  // Load addresses never wrap wider than 16 bits.
  localparam int AW = (ADDR_WIDTH > 16) ? 16 : ADDR_WIDTH;

  obl_phase_t    phase_r, phase_nxt;
  obl_kind_t     kind_r, kind_nxt;
  logic [7:0]    high_r, high_nxt;
  logic          half_r, half_nxt;
  logic [AW-1:0] addr_r, addr_nxt;
  logic [15:0]   count_r, count_nxt;
  logic [15:0]   word;
  logic [15:0]   count_dec;

  assign word      = {high_r, byte_value};
  assign count_dec = count_r - 16'd1;

  always_comb begin
    phase_nxt  = phase_r;
    kind_nxt   = kind_r;
    high_nxt   = high_r;
    half_nxt   = half_r;
    addr_nxt   = addr_r;
    count_nxt  = count_r;
    res.valid  = 1'b0;
    res.addr   = 16'd0;
    res.data   = 16'd0;
    res.status = ST_WRITE;

    if (end_of_file) begin
      phase_nxt = PH_HEADER;
      kind_nxt  = KIND_NONE;
      high_nxt  = 8'd0;
      half_nxt  = 1'b0;
      addr_nxt  = '0;
      count_nxt = 16'd0;
      res.valid  = (phase_r != PH_ERROR);
      res.status = (phase_r == PH_HEADER) ? ST_DONE : ST_TRUNC;
    end else if (phase_r == PH_ERROR) begin
      phase_nxt = PH_ERROR;
    end else if (phase_r == PH_BYTES) begin
      count_nxt = count_dec;
      if (count_dec == 16'd0) begin
        phase_nxt = PH_HEADER;
        kind_nxt  = KIND_NONE;
      end
    end else if (!half_r) begin
      high_nxt = byte_value;
      half_nxt = 1'b1;
    end else begin
      half_nxt = 1'b0;
      case (phase_r)
        PH_HEADER: begin
          if (word == HDR_CODE) begin
            kind_nxt  = KIND_CODE;
            phase_nxt = PH_ADDR;
          end else if (word == HDR_DATA) begin
            kind_nxt  = KIND_DATA;
            phase_nxt = PH_ADDR;
          end else if (word == HDR_SYM) begin
            kind_nxt  = KIND_SYM;
            phase_nxt = PH_ADDR;
          end else if (word == HDR_FNAME) begin
            kind_nxt  = KIND_FNAME;
            phase_nxt = PH_COUNT;
          end else if (word == HDR_LINE) begin
            kind_nxt  = KIND_LINE;
            count_nxt = LINE_WORDS;
            phase_nxt = PH_WORDS;
          end else begin
            kind_nxt   = KIND_NONE;
            phase_nxt  = PH_ERROR;
            res.valid  = 1'b1;
            res.status = ST_BADHDR;
          end
        end
        PH_ADDR: begin
          if (kind_r == KIND_CODE || kind_r == KIND_DATA) begin
            addr_nxt = word[AW-1:0];
          end
          phase_nxt = PH_COUNT;
        end
        PH_COUNT: begin
          count_nxt = word;
          if (word == 16'd0) begin
            phase_nxt = PH_HEADER;
            kind_nxt  = KIND_NONE;
          end else if (kind_r == KIND_SYM || kind_r == KIND_FNAME) begin
            phase_nxt = PH_BYTES;
          end else begin
            phase_nxt = PH_WORDS;
          end
        end
        PH_WORDS: begin
          if (kind_r == KIND_CODE || kind_r == KIND_DATA) begin
            res.valid  = 1'b1;
            res.addr   = 16'(addr_r);
            res.data   = word;
            res.status = ST_WRITE;
            addr_nxt   = addr_r + 1'b1;
          end
          count_nxt = count_dec;
          if (count_dec == 16'd0) begin
            phase_nxt = PH_HEADER;
            kind_nxt  = KIND_NONE;
          end
        end
        default: begin
          phase_nxt = phase_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEADER;
      kind_r  <= KIND_NONE;
      high_r  <= 8'd0;
      half_r  <= 1'b0;
      addr_r  <= '0;
      count_r <= 16'd0;
    end else if (step_en) begin
      phase_r <= phase_nxt;
      kind_r  <= kind_nxt;
      high_r  <= high_nxt;
      half_r  <= half_nxt;
      addr_r  <= addr_nxt;
      count_r <= count_nxt;
    end
  end

  assign pstat.at_header = (phase_r == PH_HEADER);
  assign pstat.in_error  = (phase_r == PH_ERROR);

endmodule

// File: sim/tb.sv
`timescale 1ns / 100ps
// Testbench for object_block_loader: streams object files byte by byte and checks every
// memory write and status record against a cycle-free parser model kept in this file.
// Depends on obl_pkg and the object_block_loader RTL.
module tb import obl_pkg::*; ();

  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_BYTES = 950;
  localparam int TAIL_BYTES   = 100;

  typedef struct packed {
    logic [15:0] addr;
    logic [15:0] data;
    obl_status_t status;
  } mem_record_t;

  typedef struct {
    logic [7:0] value;
    logic       eof;
    logic       wait_idle;
  } stream_byte_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_byte_value = 8'h00;
  logic        in_end_of_file = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] out_write_address;
  logic [15:0] out_write_data;
  logic [1:0]  out_status;

  object_block_loader dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_byte_value    (in_byte_value),
    .in_end_of_file   (in_end_of_file),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_write_address(out_write_address),
    .out_write_data   (out_write_data),
    .out_status       (out_status)
  );

  always #5 clk = ~clk;

  stream_byte_t byte_stream[$];
  mem_record_t  due_records[$];
  int           accepted_count = 0;
  int           offered_idx = 0;
  int           cycle_count = 0;
  int           errors = 0;
  int           send_gap = 0;
  int           stall_left = 0;
  int           seen_status[4];

  // Parser state mirrored from the block.
  obl_phase_t  cur_phase;
  obl_kind_t   cur_kind;
  logic [7:0]  hi_byte;
  logic        have_hi;
  logic [15:0] load_addr;
  logic [15:0] words_left;

  task automatic reset_parser();
    cur_phase  = PH_HEADER;
    cur_kind   = KIND_NONE;
    hi_byte    = 8'h00;
    have_hi    = 1'b0;
    load_addr  = 16'h0000;
    words_left = 16'h0000;
  endtask

  task automatic close_block();
    cur_phase  = PH_HEADER;
    cur_kind   = KIND_NONE;
    words_left = 16'h0000;
  endtask

  task automatic log_record(input logic [15:0] a, input logic [15:0] d, input obl_status_t s);
    mem_record_t r;
    r.addr   = a;
    r.data   = d;
    r.status = s;
    due_records.push_back(r);
  endtask

  task automatic parse_byte(input logic [7:0] b, input logic eof);
    logic [15:0] w;
    obl_phase_t  was;
    if (eof) begin
      was = cur_phase;
      reset_parser();
      if (was == PH_HEADER) begin
        log_record(16'h0000, 16'h0000, ST_DONE);
      end else if (was != PH_ERROR) begin
        log_record(16'h0000, 16'h0000, ST_TRUNC);
      end
    end else if (cur_phase == PH_BYTES) begin
      // Skipped bytes are counted singly, outside the word pairing.
      words_left = words_left - 16'd1;
      if (words_left == 16'd0) close_block();
    end else if (cur_phase != PH_ERROR) begin
      if (!have_hi) begin
        hi_byte = b;
        have_hi = 1'b1;
      end else begin
        have_hi = 1'b0;
        w = {hi_byte, b};
        case (cur_phase)
          PH_HEADER: begin
            if (w == HDR_CODE) begin
              cur_kind  = KIND_CODE;
              cur_phase = PH_ADDR;
            end else if (w == HDR_DATA) begin
              cur_kind  = KIND_DATA;
              cur_phase = PH_ADDR;
            end else if (w == HDR_SYM) begin
              cur_kind  = KIND_SYM;
              cur_phase = PH_ADDR;
            end else if (w == HDR_FNAME) begin
              cur_kind  = KIND_FNAME;
              cur_phase = PH_COUNT;
            end else if (w == HDR_LINE) begin
              cur_kind   = KIND_LINE;
              words_left = LINE_WORDS;
              cur_phase  = PH_WORDS;
            end else begin
              cur_phase = PH_ERROR;
              cur_kind  = KIND_NONE;
              log_record(16'h0000, 16'h0000, ST_BADHDR);
            end
          end
          PH_ADDR: begin
            if (cur_kind == KIND_CODE || cur_kind == KIND_DATA) load_addr = w;
            cur_phase = PH_COUNT;
          end
          PH_COUNT: begin
            words_left = w;
            if (w == 16'd0) begin
              close_block();
            end else if (cur_kind == KIND_SYM || cur_kind == KIND_FNAME) begin
              cur_phase = PH_BYTES;
            end else begin
              cur_phase = PH_WORDS;
            end
          end
          PH_WORDS: begin
            if (cur_kind == KIND_CODE || cur_kind == KIND_DATA) begin
              log_record(load_addr, w, ST_WRITE);
              load_addr = load_addr + 16'd1;
            end
            words_left = words_left - 16'd1;
            if (words_left == 16'd0) close_block();
          end
          default: ;
        endcase
      end
    end
  endtask

  task automatic put_byte(input logic [7:0] v);
    stream_byte_t item;
    item.value     = v;
    item.eof       = 1'b0;
    item.wait_idle = 1'b0;
    byte_stream.push_back(item);
  endtask

  task automatic put_word(input logic [15:0] w);
    put_byte(w[15:8]);
    put_byte(w[7:0]);
  endtask

  task automatic put_eof();
    stream_byte_t item;
    item.value     = 8'($urandom_range(0, 255));
    item.eof       = 1'b1;
    item.wait_idle = 1'b0;
    byte_stream.push_back(item);
  endtask

  function automatic logic [15:0] some_word();
    case ($urandom_range(0, 7))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom_range(0, 16'hFFFF));
    endcase
  endfunction

  // One well-formed block of a random kind with small counts.
  task automatic add_block();
    int n;
    n = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 6);
    case ($urandom_range(0, 8))
      0, 1, 2, 3, 4, 5: begin
        put_word(($urandom_range(0, 1) == 0) ? HDR_CODE : HDR_DATA);
        if ($urandom_range(0, 3) == 0) begin
          put_word(16'hFFFF - 16'($urandom_range(0, 3)));
        end else begin
          put_word(some_word());
        end
        put_word(16'(n));
        repeat (n) put_word(some_word());
      end
      6: begin
        put_word(HDR_SYM);
        put_word(some_word());
        put_word(16'(n));
        repeat (n) put_byte(8'($urandom_range(0, 255)));
      end
      7: begin
        put_word(HDR_FNAME);
        put_word(16'(n));
        repeat (n) put_byte(8'($urandom_range(0, 255)));
      end
      default: begin
        put_word(HDR_LINE);
        repeat (3) put_word(some_word());
      end
    endcase
  endtask

  // Driver: holds a transaction until it is taken, idles in bursts except near the end.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && accepted_count == offered_idx) begin
      in_valid <= 1'b1;
    end else if (accepted_count >= byte_stream.size()) begin
      in_valid <= 1'b0;
    end else if (byte_stream[accepted_count].wait_idle && due_records.size() != 0) begin
      in_valid <= 1'b0;
    end else if (send_gap > 0) begin
      send_gap = send_gap - 1;
      in_valid <= 1'b0;
    end else if (accepted_count + TAIL_BYTES < byte_stream.size() &&
                 $urandom_range(0, 7) == 0) begin
      send_gap = $urandom_range(0, 9);
      in_valid <= 1'b0;
    end else begin
      offered_idx = accepted_count;
      in_valid       <= 1'b1;
      in_byte_value  <= byte_stream[accepted_count].value;
      in_end_of_file <= byte_stream[accepted_count].eof;
    end
  end

  always @(negedge clk) begin
    if (!rst_n || accepted_count + TAIL_BYTES >= byte_stream.size()) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left = stall_left - 1;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 9);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Monitor: checks a result transaction, then folds the accepted input into the model.
  always @(posedge clk) begin
    mem_record_t want;
    cycle_count = cycle_count + 1;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        seen_status[out_status] = seen_status[out_status] + 1;
        if (due_records.size() == 0) begin
          $display("%0t: unexpected result addr %h data %h status %0d", $time,
                   out_write_address, out_write_data, out_status);
          errors = errors + 1;
        end else begin
          want = due_records.pop_front();
          if (out_write_address !== want.addr) begin
            $display("%0t: write_address expected %h, got %h", $time, want.addr,
                     out_write_address);
            errors = errors + 1;
          end
          if (out_write_data !== want.data) begin
            $display("%0t: write_data expected %h, got %h", $time, want.data, out_write_data);
            errors = errors + 1;
          end
          if (out_status !== want.status) begin
            $display("%0t: status expected %0d, got %0d", $time, want.status, out_status);
            errors = errors + 1;
          end
        end
      end
      if (in_valid && !in_stall) begin
        parse_byte(in_byte_value, in_end_of_file);
        accepted_count = accepted_count + 1;
      end
    end
  end

  initial begin
    int directed_len;
    int files;
    int flavor;
    int first;
    int mark;
    int cut;
    logic timed_out;
    reset_parser();
    for (int i = 0; i < 4; i++) seen_status[i] = 0;

    // Directed files: empty file, wrapping code block, zero count, unknown header,
    // lone header byte at end of file, and a line block cut short.
    put_eof();
    put_word(HDR_CODE);
    put_word(16'hFFFF);
    put_word(16'd2);
    put_word(16'h0000);
    put_word(16'hFFFF);
    put_word(HDR_DATA);
    put_word(16'h1234);
    put_word(16'h0000);
    put_eof();
    put_word(16'hFF00);
    put_byte(8'hA5);
    put_eof();
    put_byte(8'h71);
    put_eof();
    put_word(HDR_LINE);
    put_byte(8'h00);
    put_eof();
    directed_len = byte_stream.size();

    files = 0;
    while (byte_stream.size() < directed_len + RANDOM_BYTES) begin
      flavor = $urandom_range(0, 19);
      first = byte_stream.size();
      if (flavor < 14) begin
        repeat ($urandom_range(1, 4)) add_block();
      end else if (flavor < 16) begin
        repeat ($urandom_range(0, 3)) add_block();
        mark = byte_stream.size();
        add_block();
        cut = $urandom_range(1, byte_stream.size() - mark - 1);
        repeat (cut) void'(byte_stream.pop_back());
      end else if (flavor == 16) begin
        repeat ($urandom_range(0, 2)) add_block();
        put_word(16'($urandom_range(0, 16'hFFFF)));
        repeat ($urandom_range(0, 8)) put_byte(8'($urandom_range(0, 255)));
      end else if (flavor == 17) begin
        repeat ($urandom_range(0, 3)) add_block();
        put_byte(8'($urandom_range(0, 255)));
      end else if (flavor == 18) begin
        // A maximal count that the file never fills.
        if ($urandom_range(0, 1) == 0) begin
          put_word(HDR_CODE);
          put_word(some_word());
          put_word(16'hFFFF);
          repeat ($urandom_range(0, 4)) put_word(some_word());
        end else begin
          put_word(HDR_SYM);
          put_word(some_word());
          put_word(16'hFFFF);
          repeat ($urandom_range(0, 6)) put_byte(8'($urandom_range(0, 255)));
        end
      end else begin
        repeat ($urandom_range(1, 12)) put_byte(8'($urandom_range(0, 255)));
      end
      put_eof();
      if (files == 0 || $urandom_range(0, 9) == 0) byte_stream[first].wait_idle = 1'b1;
      files = files + 1;
    end

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while ((accepted_count < byte_stream.size() || due_records.size() != 0) &&
           cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
    end
    timed_out = (cycle_count >= CYCLE_LIMIT);
    if (timed_out) begin
      $display("%0t: timed out with %0d bytes taken, %0d results outstanding", $time,
               accepted_count, due_records.size());
      $display("tb: errors");
    end else begin
      repeat (10) @(posedge clk);
      $display("tb: %0d bytes in %0d files; %0d writes, %0d finished, %0d truncated,",
               accepted_count, files + 5, seen_status[ST_WRITE], seen_status[ST_DONE],
               seen_status[ST_TRUNC]);
      $display("tb: %0d bad headers, %0d mismatches", seen_status[ST_BADHDR], errors);
      if (errors == 0 && due_records.size() == 0) begin
        $display("tb: clean");
      end else begin
        $display("tb: errors");
      end
    end
    $finish;
  end

endmodule
